### rtl/core/lvau_pkg.sv
// Shared types, constants and codes for the Langevin Verlet atom update block.
package lvau_pkg;

  // Field widths
  localparam int DATA_W        = 32;  // signed coordinates, velocities, forces
  localparam int CFG_W         = 31;  // unsigned step registers, scale, inverse mass
  localparam int FRIC_W        = 18;  // friction factors
  localparam int CFG_IDX_W     = 3;
  localparam int DEF_FRAC_BITS = 16;

  // Integrator commands
  typedef enum logic [1:0] {
    CMD_INIT_POS  = 2'd0,
    CMD_POS_STEP  = 2'd1,
    CMD_VEL_HALF1 = 2'd2,
    CMD_VEL_HALF2 = 2'd3
  } cmd_t;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SQUARED      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP_SQUARED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_A        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_INV_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_STEP     = 3'd6;

  // Saturated value with its clip flag
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } fx_t;

endpackage

### rtl/core/langevin_verlet_atom_update.sv
// Top level: seven-stage pipelined Langevin (BBK) Verlet update of one atom axis.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command and its operands per
//   transaction; output channel (out_valid / out_stall) returns new coordinate,
//   new velocity, random force and a saturation flag, one result per input. The
//   user writes registers (cfg_we, cfg_index, cfg_data) only while no transaction
//   is in flight, which the block does not enforce; other indexes are ignored.
// Timing:
//   A transaction reaches out_valid through the stage registers s1 to s6 and the
//   output register. Throughput is one transaction per cycle while out_stall does
//   not hold the pipeline. Each path through a stage holds one 32x32 multiply
//   with rounding and saturation or one saturating add, which sets the depth.
// Reset (rst, synchronous, active high):
//   Clears all stage valid bits and loads the step and friction registers with
//   their defaults (dt = 1.0, A = 1/B = 1.0).
// Stall:
//   When out_stall holds a result, the stages behind it keep moving until they
//   close up on it; in_stall rises only once stage one cannot move.
module langevin_verlet_atom_update
  import lvau_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // register write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic signed [DATA_W-1:0] coord,
  input  logic signed [DATA_W-1:0] old_coord,
  input  logic signed [DATA_W-1:0] vel_in,
  input  logic signed [DATA_W-1:0] force_in,
  input  logic signed [DATA_W-1:0] noise_sample,
  input  logic [CFG_W-1:0]         noise_scale,
  input  logic signed [DATA_W-1:0] prior_random_force,
  input  logic [CFG_W-1:0]         inverse_mass,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] new_coord,
  output logic signed [DATA_W-1:0] new_vel,
  output logic signed [DATA_W-1:0] new_random_force,
  output logic                     saturated
);

  localparam int PROD_W = 2 * DATA_W;
  localparam logic signed [PROD_W-1:0] MUL_ROUND = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PROD_W-1:0] LIM_HI    = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [PROD_W-1:0] LIM_LO    = -LIM_HI - PROD_W'(1);
  localparam logic signed [DATA_W-1:0] VAL_HI    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_LO    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]  CFG_ONE  = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0]  CFG_HALF = CFG_W'(1) << (FRAC_BITS - 1);
  localparam logic [FRIC_W-1:0] FRIC_ONE = FRIC_W'(1) << FRAC_BITS;

  // Product, round half up, floor shift, saturate
  function automatic fx_t fx_mul(input logic signed [DATA_W-1:0] a,
                                 input logic signed [DATA_W-1:0] b);
    logic signed [PROD_W-1:0] ax;
    logic signed [PROD_W-1:0] bx;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] r;
    fx_t res;
    ax = PROD_W'(a);
    bx = PROD_W'(b);
    q  = ax * bx + MUL_ROUND;
    r  = q >>> FRAC_BITS;
    res.sat = (r > LIM_HI) || (r < LIM_LO);
    if (r > LIM_HI) begin
      res.val = VAL_HI;
    end else if (r < LIM_LO) begin
      res.val = VAL_LO;
    end else begin
      res.val = r[DATA_W-1:0];
    end
    return res;
  endfunction

  // Saturating add or subtract
  function automatic fx_t fx_add(input logic signed [DATA_W-1:0] a,
                                 input logic signed [DATA_W-1:0] b,
                                 input logic                     sub);
    logic signed [DATA_W:0] s;
    fx_t res;
    s = sub ? ((DATA_W+1)'(a) - (DATA_W+1)'(b)) : ((DATA_W+1)'(a) + (DATA_W+1)'(b));
    res.sat = (s[DATA_W] != s[DATA_W-1]);
    if (!res.sat) begin
      res.val = s[DATA_W-1:0];
    end else if (s[DATA_W]) begin
      res.val = VAL_LO;
    end else begin
      res.val = VAL_HI;
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] ux(input logic [CFG_W-1:0] v);
    return $signed({{(DATA_W-CFG_W){1'b0}}, v});
  endfunction

  function automatic logic signed [DATA_W-1:0] fx(input logic [FRIC_W-1:0] v);
    return $signed({{(DATA_W-FRIC_W){1'b0}}, v});
  endfunction

  // Configuration registers
  logic [CFG_W-1:0]  time_step;
  logic [CFG_W-1:0]  half_step;
  logic [CFG_W-1:0]  step_squared;
  logic [CFG_W-1:0]  half_step_squared;
  logic [FRIC_W-1:0] friction_a;
  logic [FRIC_W-1:0] friction_inv_b;
  logic [CFG_W-1:0]  half_inv_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step         <= CFG_ONE;
      half_step         <= CFG_HALF;
      step_squared      <= CFG_ONE;
      half_step_squared <= CFG_HALF;
      friction_a        <= FRIC_ONE;
      friction_inv_b    <= FRIC_ONE;
      half_inv_step     <= CFG_HALF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:         time_step         <= cfg_data;
        REG_HALF_STEP:         half_step         <= cfg_data;
        REG_STEP_SQUARED:      step_squared      <= cfg_data;
        REG_HALF_STEP_SQUARED: half_step_squared <= cfg_data;
        REG_FRICTION_A:        friction_a        <= cfg_data[FRIC_W-1:0];
        REG_FRICTION_INV_B:    friction_inv_b    <= cfg_data[FRIC_W-1:0];
        REG_HALF_INV_STEP:     half_inv_step     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance chain; stage 7 is the output register
  logic [6:1] vld;
  logic [7:1] adv;

  always_comb begin
    adv[7] = !out_valid || !out_stall;
    adv[6] = !vld[6] || adv[7];
    adv[5] = !vld[5] || adv[6];
    adv[4] = !vld[4] || adv[5];
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (adv[7]) begin
        out_valid <= vld[6];
      end
    end
  end

  // Stage 1: step-factor times inverse mass, R times noise, v/x_old product, 2x
  cmd_t                     cmd_in;
  logic [CFG_W-1:0]         k_sel;
  logic signed [DATA_W-1:0] pa_sel;
  logic signed [DATA_W-1:0] pb_sel;
  fx_t                      m1a, m1b, m1c, d1;
  logic                     sat1_next;

  always_comb begin
    cmd_in = cmd_t'(cmd);
    case (cmd_in)
      CMD_INIT_POS: k_sel = half_step_squared;
      CMD_POS_STEP: k_sel = step_squared;
      default:      k_sel = half_step;
    endcase
    pa_sel = (cmd_in == CMD_INIT_POS) ? ux(time_step) : fx(friction_a);
    pb_sel = (cmd_in == CMD_POS_STEP) ? old_coord : vel_in;
    m1a = fx_mul(ux(k_sel), ux(inverse_mass));
    m1b = fx_mul(ux(noise_scale), noise_sample);
    m1c = fx_mul(pa_sel, pb_sel);
    d1  = fx_add(coord, coord, 1'b0);
    sat1_next = m1a.sat
              | (m1b.sat && (cmd_in == CMD_POS_STEP || cmd_in == CMD_VEL_HALF2))
              | (m1c.sat && (cmd_in != CMD_VEL_HALF2))
              | (d1.sat  && (cmd_in == CMD_POS_STEP));
  end

  cmd_t                     s1_cmd;
  logic signed [DATA_W-1:0] s1_coord, s1_old, s1_vel, s1_force, s1_prior;
  logic signed [DATA_W-1:0] s1_ka, s1_nf, s1_pc, s1_dbl;
  logic                     s1_sat;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_cmd   <= cmd_in;
      s1_coord <= coord;
      s1_old   <= old_coord;
      s1_vel   <= vel_in;
      s1_force <= force_in;
      s1_prior <= prior_random_force;
      s1_ka    <= m1a.val;
      s1_nf    <= m1b.val;
      s1_pc    <= m1c.val;
      s1_dbl   <= d1.val;
      s1_sat   <= sat1_next;
    end
  end

  // Stage 2: total force and coordinate partial sum
  fx_t f2, a2;

  always_comb begin
    case (s1_cmd)
      CMD_INIT_POS: begin
        f2 = {s1_force, 1'b0};
        a2 = fx_add(s1_coord, s1_pc, 1'b0);
      end
      CMD_POS_STEP: begin
        f2 = fx_add(s1_force, s1_nf, 1'b0);
        a2 = fx_add(s1_dbl, s1_pc, 1'b1);
      end
      CMD_VEL_HALF1: begin
        f2 = fx_add(s1_force, s1_prior, 1'b0);
        a2 = {s1_pc, 1'b0};
      end
      default: begin
        f2 = fx_add(s1_force, s1_nf, 1'b0);
        a2 = {s1_pc, 1'b0};
      end
    endcase
  end

  cmd_t                     s2_cmd;
  logic signed [DATA_W-1:0] s2_coord, s2_old, s2_vel, s2_prior, s2_nf;
  logic signed [DATA_W-1:0] s2_ka, s2_fsum, s2_acc;
  logic                     s2_sat;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_cmd   <= s1_cmd;
      s2_coord <= s1_coord;
      s2_old   <= s1_old;
      s2_vel   <= s1_vel;
      s2_prior <= s1_prior;
      s2_nf    <= s1_nf;
      s2_ka    <= s1_ka;
      s2_fsum  <= f2.val;
      s2_acc   <= a2.val;
      s2_sat   <= s1_sat | f2.sat | a2.sat;
    end
  end

  // Stage 3: scaled force term
  fx_t t3;

  assign t3 = fx_mul(s2_ka, s2_fsum);

  cmd_t                     s3_cmd;
  logic signed [DATA_W-1:0] s3_coord, s3_old, s3_vel, s3_prior, s3_nf;
  logic signed [DATA_W-1:0] s3_acc, s3_t;
  logic                     s3_sat;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_cmd   <= s2_cmd;
      s3_coord <= s2_coord;
      s3_old   <= s2_old;
      s3_vel   <= s2_vel;
      s3_prior <= s2_prior;
      s3_nf    <= s2_nf;
      s3_acc   <= s2_acc;
      s3_t     <= t3.val;
      s3_sat   <= s2_sat | t3.sat;
    end
  end

  // Stage 4: add force term to coordinate sum or velocity
  fx_t x4;

  assign x4 = fx_add((s3_cmd == CMD_VEL_HALF2) ? s3_vel : s3_acc, s3_t, 1'b0);

  cmd_t                     s4_cmd;
  logic signed [DATA_W-1:0] s4_coord, s4_old, s4_vel, s4_prior, s4_nf, s4_x;
  logic                     s4_sat;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_cmd   <= s3_cmd;
      s4_coord <= s3_coord;
      s4_old   <= s3_old;
      s4_vel   <= s3_vel;
      s4_prior <= s3_prior;
      s4_nf    <= s3_nf;
      s4_x     <= x4.val;
      s4_sat   <= s3_sat | x4.sat;
    end
  end

  // Stage 5: damping by 1/B, or dt times new velocity
  fx_t m5;

  assign m5 = fx_mul((s4_cmd == CMD_VEL_HALF1) ? ux(time_step) : fx(friction_inv_b), s4_x);

  cmd_t                     s5_cmd;
  logic signed [DATA_W-1:0] s5_coord, s5_old, s5_vel, s5_prior, s5_nf, s5_x, s5_p;
  logic                     s5_sat;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_cmd   <= s4_cmd;
      s5_coord <= s4_coord;
      s5_old   <= s4_old;
      s5_vel   <= s4_vel;
      s5_prior <= s4_prior;
      s5_nf    <= s4_nf;
      s5_x     <= s4_x;
      s5_p     <= m5.val;
      s5_sat   <= s4_sat | (m5.sat && (s4_cmd != CMD_INIT_POS));
    end
  end

  // Stage 6: coordinate difference, or coordinate advance
  fx_t y6;

  assign y6 = (s5_cmd == CMD_POS_STEP) ? fx_add(s5_p, s5_old, 1'b1)
                                       : fx_add(s5_coord, s5_p, 1'b0);

  cmd_t                     s6_cmd;
  logic signed [DATA_W-1:0] s6_coord, s6_vel, s6_prior, s6_nf, s6_x, s6_p, s6_y;
  logic                     s6_sat;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_cmd   <= s5_cmd;
      s6_coord <= s5_coord;
      s6_vel   <= s5_vel;
      s6_prior <= s5_prior;
      s6_nf    <= s5_nf;
      s6_x     <= s5_x;
      s6_p     <= s5_p;
      s6_y     <= y6.val;
      s6_sat   <= s5_sat |
                  (y6.sat && (s5_cmd == CMD_POS_STEP || s5_cmd == CMD_VEL_HALF1));
    end
  end

  // Stage 7: central-difference velocity and result selection
  fx_t                      m7;
  logic signed [DATA_W-1:0] coord_next, vel_next, rf_next;
  logic                     sat_next;

  always_comb begin
    m7       = fx_mul(ux(half_inv_step), s6_y);
    rf_next  = s6_prior;
    sat_next = s6_sat;
    case (s6_cmd)
      CMD_INIT_POS: begin
        coord_next = s6_x;
        vel_next   = s6_vel;
      end
      CMD_POS_STEP: begin
        coord_next = s6_p;
        vel_next   = m7.val;
        sat_next   = s6_sat | m7.sat;
      end
      CMD_VEL_HALF1: begin
        coord_next = s6_y;
        vel_next   = s6_x;
      end
      default: begin
        coord_next = s6_coord;
        vel_next   = s6_p;
        rf_next    = s6_nf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      new_coord        <= coord_next;
      new_vel          <= vel_next;
      new_random_force <= rf_next;
      saturated        <= sat_next;
    end
  end

endmodule

### rtl/core/lvau_checker.sv
// Port-level checker for the atom update block, with its bind.
module lvau_checker
  import lvau_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] new_coord,
  input logic signed [DATA_W-1:0] new_vel,
  input logic signed [DATA_W-1:0] new_random_force,
  input logic                     saturated
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(new_coord) && $stable(new_vel) &&
                               $stable(new_random_force) && $stable(saturated))
    else $error("stalled result changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Input backpressure only arises from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind langevin_verlet_atom_update lvau_checker u_lvau_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .new_coord        (new_coord),
  .new_vel          (new_vel),
  .new_random_force (new_random_force),
  .saturated        (saturated)
);
